>>> design/mtp_pkg.sv
// ----------------------------------------------------------------------------
// Masked trilinear prolongation: shared package
// Register indexes, field widths, corner order and mean shift of the
// coarse-to-fine prolongation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mtp_pkg;

   localparam int DIM_REG_BITS   = 8;
   localparam int FINE_REG_BITS  = 9;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 9;
   localparam int MASK_BITS      = 8;
   localparam int ADDR_BITS      = 24;
   localparam int CORNERS        = 8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COARSE_WIDTH  = 3'd0,
      CSR_COARSE_HEIGHT = 3'd1,
      CSR_COARSE_DEPTH  = 3'd2,
      CSR_FINE_WIDTH    = 3'd3,
      CSR_FINE_HEIGHT   = 3'd4
   } csr_index_type;

   // corner code: bit 0 = x offset, bit 1 = y offset, bit 2 = z offset
   typedef logic [2:0] corner_type;

   localparam corner_type LAST_READ = 3'd6;
   localparam corner_type LAST_BEAT = 3'd7;

   localparam corner_type CORNER_ORDER [CORNERS] = '{
      3'd0, 3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7
   };

   function automatic logic [1:0] mean_shift(input corner_type sel);
      return 2'(sel[0]) + 2'(sel[1]) + 2'(sel[2]);
   endfunction

endpackage

`default_nettype wire

>>> design/mtp_if.sv
// ----------------------------------------------------------------------------
// Masked trilinear prolongation: channel interfaces
// Request channel carries coarse samples, response channel fine samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtp_req_if #(
   parameter int VALUE_BITS = 32
) ();
   logic                                valid;
   logic                                ready;
   logic signed [VALUE_BITS-1:0]        coarse_value;
   logic [mtp_pkg::MASK_BITS-1:0]       fine_mask;

   modport source (output valid, coarse_value, fine_mask, input ready);
   modport sink   (input valid, coarse_value, fine_mask, output ready);
endinterface

interface mtp_rsp_if #(
   parameter int VALUE_BITS = 32
) ();
   logic                                valid;
   logic                                ready;
   logic signed [VALUE_BITS-1:0]        fine_value;
   logic [mtp_pkg::ADDR_BITS-1:0]       fine_address;
   logic                                last_of_run;

   modport source (output valid, fine_value, fine_address, last_of_run, input ready);
   modport sink   (input valid, fine_value, fine_address, last_of_run, output ready);
endinterface

`default_nettype wire

>>> design/masked_trilinear_prolongation_unit.sv
// ----------------------------------------------------------------------------
// Masked trilinear prolongation unit
// Coarse samples enter on req_bus in raster order (x, then y, then z), each
// with an eight-bit mask. Once a 2x2x2 neighbourhood is complete, eight fine
// samples leave on rsp_bus with their linear fine address; the eighth beat
// carries last_of_run. A clear mask bit gives a zero sample.
// Sizes are set through the csr_ write port; the user must write them only
// while the unit is idle, which the unit itself leaves unchecked. Each
// sample is written to a two-plane store; the seven stored corners are read
// one per cycle from its single read port and summed as they return. A
// request that completes no neighbourhood starts no reads. The seven reads
// of the next request overlap the eight beats of the current one.
// Reset clears the position counters and loads the default sizes; the store
// needs no clearing pass. When rsp_bus stalls, the output register holds
// its beat, one finished neighbourhood waits and req_bus.ready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_trilinear_prolongation_unit #(
   parameter int MAX_COARSE_DIM = 128,
   parameter int VALUE_BITS     = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [mtp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [mtp_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   mtp_req_if.sink                                   req_bus,
   mtp_rsp_if.source                                 rsp_bus
);

   localparam int CW        = $clog2(MAX_COARSE_DIM);
   localparam int DW        = $clog2(MAX_COARSE_DIM + 1);
   localparam int EW        = (DW > mtp_pkg::DIM_REG_BITS) ? DW : mtp_pkg::DIM_REG_BITS;
   localparam int FW        = CW + 1;
   localparam int AW        = VALUE_BITS + 3;
   localparam int RAM_ABITS = 2 * CW + 1;
   localparam int RAM_DEPTH = 1 << RAM_ABITS;
   localparam int AB        = mtp_pkg::ADDR_BITS;
   localparam int NC        = mtp_pkg::CORNERS;

   // configuration
   logic [mtp_pkg::DIM_REG_BITS-1:0]  coarse_width_ff, coarse_width_in;
   logic [mtp_pkg::DIM_REG_BITS-1:0]  coarse_height_ff, coarse_height_in;
   logic [mtp_pkg::DIM_REG_BITS-1:0]  coarse_depth_ff, coarse_depth_in;
   logic [mtp_pkg::FINE_REG_BITS-1:0] fine_width_ff, fine_width_in;
   logic [mtp_pkg::FINE_REG_BITS-1:0] fine_height_ff, fine_height_in;

   // position counters
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] plane_ff, plane_in;
   logic [EW-1:0] col_up, row_up, plane_up;
   logic [EW-1:0] eff_w, eff_h, eff_d;

   // gather sequencer
   logic                    busy_ff, busy_in;
   mtp_pkg::corner_type     phase_ff, phase_in;
   logic                    rd_vld_ff, rd_vld_in;
   mtp_pkg::corner_type     rd_q_ff, rd_q_in;
   logic                    acc_full_ff, acc_full_in;
   logic signed [AW-1:0]    acc_ff [NC];
   logic signed [AW-1:0]    acc_in [NC];

   // item registers
   logic [CW-1:0]                  bc_ff, bc_in, br_ff, br_in;
   logic                           bp_ff, bp_in;
   logic [mtp_pkg::MASK_BITS-1:0]  mask_ff, mask_in;
   logic [FW-1:0]                  fx0_ff, fx0_in, fy0_ff, fy0_in, fz0_ff, fz0_in;

   // address pipeline
   logic [AB-1:0] zprod_ff, zprod_in, yrow_ff, yrow_in, base_ff, base_in, fwh_ff, fwh_in;

   // emit stage and output register
   logic                           emit_busy_ff, emit_busy_in;
   mtp_pkg::corner_type            emit_idx_ff, emit_idx_in;
   logic signed [AW-1:0]           emit_acc_ff [NC];
   logic signed [AW-1:0]           emit_acc_in [NC];
   logic [mtp_pkg::MASK_BITS-1:0]  emit_mask_ff, emit_mask_in;
   logic [AB-1:0]                  emit_base_ff, emit_base_in;
   logic                           out_vld_ff, out_vld_in;
   logic [VALUE_BITS-1:0]          out_value_ff, out_value_in;
   logic [AB-1:0]                  out_addr_ff, out_addr_in;
   logic                           out_last_ff, out_last_in;

   // handshakes and datapath
   logic                   accept, accept_ok, complete, start;
   logic                   out_take, emit_step, emit_free, emit_load;
   logic [RAM_ABITS-1:0]   wr_addr, rd_addr;
   logic [VALUE_BITS-1:0]  rd_data;
   logic signed [AW-1:0]   val_ext, rd_ext, sum_sel, mean;
   mtp_pkg::corner_type    sel;
   logic [1:0]             sh;
   logic [VALUE_BITS-1:0]  beat_value;
   logic [AB-1:0]          beat_addr;

   function automatic logic [EW-1:0] eff_dim(input logic [mtp_pkg::DIM_REG_BITS-1:0] value);
      if (value == '0) begin
         return EW'(1);
      end else if (EW'(value) > EW'(MAX_COARSE_DIM)) begin
         return EW'(MAX_COARSE_DIM);
      end else begin
         return EW'(value);
      end
   endfunction

   // ---- configuration ----
   always_comb begin
      coarse_width_in  = coarse_width_ff;
      coarse_height_in = coarse_height_ff;
      coarse_depth_in  = coarse_depth_ff;
      fine_width_in    = fine_width_ff;
      fine_height_in   = fine_height_ff;
      if (csr_write_enable) begin
         unique case (mtp_pkg::csr_index_type'(csr_index))
            mtp_pkg::CSR_COARSE_WIDTH:  coarse_width_in  = csr_write_data[mtp_pkg::DIM_REG_BITS-1:0];
            mtp_pkg::CSR_COARSE_HEIGHT: coarse_height_in = csr_write_data[mtp_pkg::DIM_REG_BITS-1:0];
            mtp_pkg::CSR_COARSE_DEPTH:  coarse_depth_in  = csr_write_data[mtp_pkg::DIM_REG_BITS-1:0];
            mtp_pkg::CSR_FINE_WIDTH:    fine_width_in    = csr_write_data;
            mtp_pkg::CSR_FINE_HEIGHT:   fine_height_in   = csr_write_data;
            default: ;
         endcase
      end
   end

   // ---- handshake ----
   assign out_take  = !out_vld_ff || rsp_bus.ready;
   assign emit_step = emit_busy_ff && out_take;
   assign emit_free = !emit_busy_ff || (emit_step && emit_idx_ff == mtp_pkg::LAST_BEAT);
   assign emit_load = acc_full_ff && emit_free;
   assign accept_ok = !busy_ff && !rd_vld_ff && (!acc_full_ff || emit_load);
   assign req_bus.ready = accept_ok;
   assign accept    = req_bus.valid && accept_ok;
   assign complete  = (col_ff >= CW'(2)) && (row_ff >= CW'(2)) && (plane_ff >= CW'(2));
   assign start     = accept && complete;

   // ---- position counters ----
   assign eff_w    = eff_dim(coarse_width_ff);
   assign eff_h    = eff_dim(coarse_height_ff);
   assign eff_d    = eff_dim(coarse_depth_ff);
   assign col_up   = EW'(col_ff) + EW'(1);
   assign row_up   = EW'(row_ff) + EW'(1);
   assign plane_up = EW'(plane_ff) + EW'(1);

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      plane_in = plane_ff;
      if (accept) begin
         if (col_up >= eff_w) begin
            col_in = '0;
            if (row_up >= eff_h) begin
               row_in = '0;
               if (plane_up >= eff_d) begin
                  plane_in = '0;
               end else begin
                  plane_in = CW'(plane_up);
               end
            end else begin
               row_in = CW'(row_up);
            end
         end else begin
            col_in = CW'(col_up);
         end
      end
   end

   // ---- plane store ----
   assign wr_addr = {plane_ff[0], row_ff, col_ff};

   always_comb begin
      if (busy_ff) begin
         rd_addr = {bp_ff ^ phase_ff[2], br_ff + CW'(phase_ff[1]), bc_ff + CW'(phase_ff[0])};
      end else begin
         rd_addr = {~plane_ff[0], row_ff - CW'(1), col_ff - CW'(1)};
      end
   end

   mtp_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_plane_store (
      .clock         (clock),
      .write_enable  (accept),
      .write_address (wr_addr),
      .write_data    (req_bus.coarse_value),
      .read_address  (rd_addr),
      .read_data     (rd_data)
   );

   // ---- gather sequencer ----
   assign val_ext = AW'(req_bus.coarse_value);
   assign rd_ext  = AW'($signed(rd_data));

   always_comb begin
      busy_in   = busy_ff;
      phase_in  = phase_ff;
      rd_vld_in = 1'b0;
      rd_q_in   = phase_ff;
      if (start) begin
         busy_in   = 1'b1;
         phase_in  = 3'd1;
         rd_vld_in = 1'b1;
         rd_q_in   = '0;
      end else if (busy_ff) begin
         rd_vld_in = 1'b1;
         phase_in  = phase_ff + 3'd1;
         if (phase_ff == mtp_pkg::LAST_READ) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      acc_full_in = acc_full_ff;
      if (rd_vld_ff && rd_q_ff == mtp_pkg::LAST_READ) begin
         acc_full_in = 1'b1;
      end else if (emit_load) begin
         acc_full_in = 1'b0;
      end
   end

   // add each returning corner into every mean that covers it
   always_comb begin
      for (int s = 0; s < NC; s++) begin
         acc_in[s] = acc_ff[s];
         if (start) begin
            acc_in[s] = (s == NC - 1) ? val_ext : '0;
         end else if (rd_vld_ff && ((rd_q_ff & ~3'(s)) == 3'd0)) begin
            acc_in[s] = acc_ff[s] + rd_ext;
         end
      end
   end

   always_comb begin
      bc_in   = bc_ff;
      br_in   = br_ff;
      bp_in   = bp_ff;
      mask_in = mask_ff;
      fx0_in  = fx0_ff;
      fy0_in  = fy0_ff;
      fz0_in  = fz0_ff;
      if (start) begin
         bc_in   = col_ff - CW'(1);
         br_in   = row_ff - CW'(1);
         bp_in   = ~plane_ff[0];
         mask_in = req_bus.fine_mask;
         fx0_in  = {col_ff, 1'b0} - FW'(3);
         fy0_in  = {row_ff, 1'b0} - FW'(3);
         fz0_in  = {plane_ff, 1'b0} - FW'(3);
      end
   end

   // ---- address pipeline ----
   always_comb begin
      zprod_in = AB'(fine_height_ff) * AB'(fz0_ff);
      yrow_in  = AB'(fine_width_ff) * (AB'(fy0_ff) + zprod_ff);
      base_in  = AB'(fx0_ff) + yrow_ff;
      fwh_in   = AB'(fine_width_ff) * AB'(fine_height_ff);
   end

   // ---- emit stage ----
   assign sel     = mtp_pkg::CORNER_ORDER[emit_idx_ff];
   assign sh      = mtp_pkg::mean_shift(sel);
   assign sum_sel = emit_acc_ff[sel];
   assign mean    = sum_sel >>> sh;

   always_comb begin
      beat_value = emit_mask_ff[emit_idx_ff] ? mean[VALUE_BITS-1:0] : '0;
      beat_addr  = emit_base_ff + (sel[2] ? fwh_ff : '0)
                   + (sel[1] ? AB'(fine_width_ff) : '0) + AB'(sel[0]);
   end

   always_comb begin
      emit_busy_in = emit_busy_ff;
      emit_idx_in  = emit_idx_ff;
      emit_acc_in  = emit_acc_ff;
      emit_mask_in = emit_mask_ff;
      emit_base_in = emit_base_ff;
      if (emit_step) begin
         emit_idx_in = emit_idx_ff + 3'd1;
         if (emit_idx_ff == mtp_pkg::LAST_BEAT) begin
            emit_busy_in = 1'b0;
         end
      end
      if (emit_load) begin
         emit_busy_in = 1'b1;
         emit_idx_in  = '0;
         emit_acc_in  = acc_ff;
         emit_mask_in = mask_ff;
         emit_base_in = base_ff;
      end
   end

   always_comb begin
      out_vld_in   = out_take ? emit_busy_ff : out_vld_ff;
      out_value_in = out_value_ff;
      out_addr_in  = out_addr_ff;
      out_last_in  = out_last_ff;
      if (emit_step) begin
         out_value_in = beat_value;
         out_addr_in  = beat_addr;
         out_last_in  = (emit_idx_ff == mtp_pkg::LAST_BEAT);
      end
   end

   assign rsp_bus.valid        = out_vld_ff;
   assign rsp_bus.fine_value   = out_value_ff;
   assign rsp_bus.fine_address = out_addr_ff;
   assign rsp_bus.last_of_run  = out_last_ff;

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         coarse_width_ff  <= mtp_pkg::DIM_REG_BITS'(64);
         coarse_height_ff <= mtp_pkg::DIM_REG_BITS'(64);
         coarse_depth_ff  <= mtp_pkg::DIM_REG_BITS'(64);
         fine_width_ff    <= mtp_pkg::FINE_REG_BITS'(127);
         fine_height_ff   <= mtp_pkg::FINE_REG_BITS'(127);
         col_ff           <= '0;
         row_ff           <= '0;
         plane_ff         <= '0;
         busy_ff          <= 1'b0;
         phase_ff         <= '0;
         rd_vld_ff        <= 1'b0;
         rd_q_ff          <= '0;
         acc_full_ff      <= 1'b0;
         emit_busy_ff     <= 1'b0;
         emit_idx_ff      <= '0;
         out_vld_ff       <= 1'b0;
      end else begin
         coarse_width_ff  <= coarse_width_in;
         coarse_height_ff <= coarse_height_in;
         coarse_depth_ff  <= coarse_depth_in;
         fine_width_ff    <= fine_width_in;
         fine_height_ff   <= fine_height_in;
         col_ff           <= col_in;
         row_ff           <= row_in;
         plane_ff         <= plane_in;
         busy_ff          <= busy_in;
         phase_ff         <= phase_in;
         rd_vld_ff        <= rd_vld_in;
         rd_q_ff          <= rd_q_in;
         acc_full_ff      <= acc_full_in;
         emit_busy_ff     <= emit_busy_in;
         emit_idx_ff      <= emit_idx_in;
         out_vld_ff       <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      bc_ff        <= bc_in;
      br_ff        <= br_in;
      bp_ff        <= bp_in;
      mask_ff      <= mask_in;
      fx0_ff       <= fx0_in;
      fy0_ff       <= fy0_in;
      fz0_ff       <= fz0_in;
      zprod_ff     <= zprod_in;
      yrow_ff      <= yrow_in;
      base_ff      <= base_in;
      fwh_ff       <= fwh_in;
      emit_acc_ff  <= emit_acc_in;
      emit_mask_ff <= emit_mask_in;
      emit_base_ff <= emit_base_in;
      out_value_ff <= out_value_in;
      out_addr_ff  <= out_addr_in;
      out_last_ff  <= out_last_in;
   end

endmodule

`default_nettype wire

>>> design/mtp_ram.sv
// ----------------------------------------------------------------------------
// Masked trilinear prolongation: generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       write_enable,
   input  wire logic [$clog2(DEPTH)-1:0]   write_address,
   input  wire logic [WIDTH-1:0]           write_data,
   input  wire logic [$clog2(DEPTH)-1:0]   read_address,
   output logic      [WIDTH-1:0]           read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Masked trilinear prolongation unit: testbench
// Streams coarse grids through the unit in raster order. A local model works
// out every fine sample, its linear address and the end-of-run marker as each
// coarse beat is taken. Each response beat is then checked, in order, against
// that model. Directed grids cover extreme values, undersized axes, a resize
// in mid-grid and a saturated depth under a long receiver hold-off. Random
// grids with random idling on both channels and sender pauses make up the
// rest.
// ----------------------------------------------------------------------------
module testbench;

   localparam int     MAX_COARSE_DIM   = 128;
   localparam int     VALUE_BITS       = 32;
   localparam int     RANDOM_ITEMS     = 100;
   localparam int     SETTLE_CYCLES    = 24;
   localparam int     DRAIN_LIMIT      = 20000;
   localparam int     LONG_HOLD_CYCLES = 400;
   localparam longint CYCLE_LIMIT      = 1000000;

   localparam logic [mtp_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;

   // emission order of the eight fine samples, as (dz dy dx) offset codes
   localparam logic [2:0] SAMPLE_ORDER [8] = '{
      3'd0, 3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7
   };
   localparam logic signed [31:0] EDGE_CORNERS [8] = '{
      VALUE_MAX, VALUE_MIN, VALUE_MAX, -32'sd1, 32'sd1, VALUE_MIN, VALUE_MAX, VALUE_MIN
   };

   typedef struct packed {
      logic signed [31:0]             value;
      logic [mtp_pkg::ADDR_BITS-1:0]  address;
      logic                           last;
   } fine_sample_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 csr_write_enable;
   logic [mtp_pkg::CSR_INDEX_BITS-1:0]   csr_index;
   logic [mtp_pkg::CSR_DATA_BITS-1:0]    csr_write_data;

   mtp_req_if #(.VALUE_BITS(VALUE_BITS)) req_bus ();
   mtp_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_bus ();

   masked_trilinear_prolongation_unit #(
      .MAX_COARSE_DIM(MAX_COARSE_DIM),
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #1 clock = ~clock;

   // model state
   logic signed [31:0]                 plane_mem [2][MAX_COARSE_DIM][MAX_COARSE_DIM];
   int unsigned                        col_pos, row_pos, plane_pos;
   logic [mtp_pkg::DIM_REG_BITS-1:0]   coarse_cols, coarse_rows, coarse_planes;
   logic [mtp_pkg::FINE_REG_BITS-1:0]  fine_row_len, fine_plane_rows;
   fine_sample_type                    pending_fine [$];

   int error_count  = 0;
   int random_items = 0;
   bit steady_send  = 1'b0;
   bit steady_flow  = 1'b0;
   bit long_hold_request = 1'b0;
   int hold_left  = 0;
   int stall_left = 0;

   function automatic int draw_gap();
      int roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(12, 4);
      return $urandom_range(60, 13);
   endfunction

   function automatic logic signed [31:0] draw_value();
      int roll = $urandom_range(99);
      if (roll < 60) return $urandom;
      if (roll < 80) return 32'($urandom_range(2047)) - 32'sd1024;
      unique case ($urandom_range(3))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return -32'sd1;
         default: return 32'sd0;
      endcase
   endfunction

   function automatic logic [mtp_pkg::MASK_BITS-1:0] draw_mask();
      int roll = $urandom_range(99);
      if (roll < 70) return mtp_pkg::MASK_BITS'($urandom);
      if (roll < 85) return '1;
      return '0;
   endfunction

   function automatic int unsigned pick_span();
      return ($urandom_range(99) < 80) ? $urandom_range(4, 3) : $urandom_range(5, 3);
   endfunction

   function automatic logic [mtp_pkg::FINE_REG_BITS-1:0] pick_fine_size(
         input int unsigned span);
      int roll = $urandom_range(99);
      if (roll < 40) return mtp_pkg::FINE_REG_BITS'(2 * span - 1);
      if (roll < 60) return mtp_pkg::FINE_REG_BITS'($urandom_range(511));
      if (roll < 75) return mtp_pkg::FINE_REG_BITS'(1);
      if (roll < 85) return mtp_pkg::FINE_REG_BITS'(0);
      return mtp_pkg::FINE_REG_BITS'(256);
   endfunction

   function automatic int unsigned axis_span(input logic [mtp_pkg::DIM_REG_BITS-1:0] size);
      if (size == 0) return 1;
      if (size > MAX_COARSE_DIM) return MAX_COARSE_DIM;
      return 32'(size);
   endfunction

   // store the coarse sample, queue the eight fine samples it completes, advance
   function automatic void predict_fine_samples(input logic signed [31:0] value,
                                                input logic [mtp_pkg::MASK_BITS-1:0] mask);
      logic signed [31:0] corner [8];
      fine_sample_type    sample;
      logic [2:0]         sel;
      longint             total, fx, fy, fz, address;
      int                 shift;
      plane_mem[plane_pos % 2][row_pos][col_pos] = value;
      if (col_pos >= 2 && row_pos >= 2 && plane_pos >= 2) begin
         for (int q = 0; q < 8; q++)
            corner[q] = plane_mem[(plane_pos - 1 + ((q >> 2) & 1)) % 2]
                                 [row_pos - 1 + ((q >> 1) & 1)]
                                 [col_pos - 1 + (q & 1)];
         for (int k = 0; k < 8; k++) begin
            sel   = SAMPLE_ORDER[k];
            shift = int'(sel[0]) + int'(sel[1]) + int'(sel[2]);
            total = 0;
            for (int q = 0; q < 8; q++)
               if ((q & ~int'(sel)) == 0) total += corner[q];
            fx = 2 * longint'(col_pos) - 3 + longint'(sel[0]);
            fy = 2 * longint'(row_pos) - 3 + longint'(sel[1]);
            fz = 2 * longint'(plane_pos) - 3 + longint'(sel[2]);
            address = fx + longint'(fine_row_len) * (fy + longint'(fine_plane_rows) * fz);
            sample.value   = mask[k] ? 32'(total >>> shift) : '0;
            sample.address = mtp_pkg::ADDR_BITS'(address);
            sample.last    = (k == 7);
            pending_fine.push_back(sample);
         end
      end
      col_pos++;
      if (col_pos >= axis_span(coarse_cols)) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= axis_span(coarse_rows)) begin
            row_pos = 0;
            plane_pos++;
            if (plane_pos >= axis_span(coarse_planes)) plane_pos = 0;
         end
      end
   endfunction

   function automatic void flag_mismatch(input string field,
                                         input logic signed [63:0] want,
                                         input logic signed [63:0] seen);
      error_count++;
      $error("%s: expected %0d, got %0d", field, want, seen);
   endfunction

   // check each response beat against the oldest queued fine sample
   always @(posedge clock) begin
      fine_sample_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_fine.size() == 0) begin
            flag_mismatch("unexpected beat, fine_address", -1, rsp_bus.fine_address);
         end else begin
            due = pending_fine.pop_front();
            if (rsp_bus.fine_value !== due.value)
               flag_mismatch("fine_value", due.value, rsp_bus.fine_value);
            if (rsp_bus.fine_address !== due.address)
               flag_mismatch("fine_address", due.address, rsp_bus.fine_address);
            if (rsp_bus.last_of_run !== due.last)
               flag_mismatch("last_of_run", due.last, rsp_bus.last_of_run);
         end
      end
   end

   // receiver: random stalls, or a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else if (long_hold_request) begin
         long_hold_request = 1'b0;
         hold_left = LONG_HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left = steady_flow ? 0 : draw_gap();
      end
   end

   initial begin : watchdog
      longint cycles_run;
      cycles_run = 0;
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("testbench: errors");
      $finish;
   end

   task automatic write_register(input logic [mtp_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [mtp_pkg::CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      unique case (index)
         mtp_pkg::CSR_COARSE_WIDTH:  coarse_cols     = data[mtp_pkg::DIM_REG_BITS-1:0];
         mtp_pkg::CSR_COARSE_HEIGHT: coarse_rows     = data[mtp_pkg::DIM_REG_BITS-1:0];
         mtp_pkg::CSR_COARSE_DEPTH:  coarse_planes   = data[mtp_pkg::DIM_REG_BITS-1:0];
         mtp_pkg::CSR_FINE_WIDTH:    fine_row_len    = data[mtp_pkg::FINE_REG_BITS-1:0];
         mtp_pkg::CSR_FINE_HEIGHT:   fine_plane_rows = data[mtp_pkg::FINE_REG_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic program_grid(input logic [mtp_pkg::CSR_DATA_BITS-1:0] cols, rows, planes,
                               input logic [mtp_pkg::CSR_DATA_BITS-1:0] fine_len, fine_rows);
      write_register(mtp_pkg::CSR_COARSE_WIDTH, cols);
      write_register(mtp_pkg::CSR_COARSE_HEIGHT, rows);
      write_register(mtp_pkg::CSR_COARSE_DEPTH, planes);
      write_register(mtp_pkg::CSR_FINE_WIDTH, fine_len);
      write_register(mtp_pkg::CSR_FINE_HEIGHT, fine_rows);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // change idling only while both channels are quiet
   task automatic set_idling(input bit send_steady, input bit rsp_steady, input bit long_hold);
      steady_send = send_steady;
      @(negedge clock);
      steady_flow = rsp_steady;
      long_hold_request = long_hold;
      @(posedge clock);
   endtask

   task automatic send_coarse_sample(input logic signed [31:0] value,
                                     input logic [mtp_pkg::MASK_BITS-1:0] mask);
      int gap;
      gap = steady_send ? 0 : draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.coarse_value <= value;
      req_bus.fine_mask    <= mask;
      do @(posedge clock); while (!req_bus.ready);
      predict_fine_samples(value, mask);
   endtask

   task automatic send_random_sample();
      send_coarse_sample(draw_value(), draw_mask());
   endtask

   // drop valid and wait until every queued fine sample is back or the drain limit runs out
   task automatic drain_results();
      int waited;
      req_bus.valid <= 1'b0;
      waited = 0;
      while (pending_fine.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_fine.size() != 0) begin
         error_count++;
         $error("fine samples missing: expected %0d more beats, got 0", pending_fine.size());
         pending_fine.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_grids(input int unsigned count);
      int unsigned beats;
      beats = axis_span(coarse_cols) * axis_span(coarse_rows) * axis_span(coarse_planes) * count;
      for (int unsigned n = 0; n < beats; n++) begin
         send_random_sample();
         if ($urandom_range(199) == 0) drain_results();
      end
   endtask

   task automatic test_extreme_values();
      logic signed [31:0] value;
      program_grid(9'd3, 9'd3, 9'd3, 9'd256, 9'd256);
      set_idling(1'b0, 1'b0, 1'b0);
      for (int p = 0; p < 3; p++)
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) begin
               if (p > 0 && r > 0 && c > 0)
                  value = EDGE_CORNERS[(c - 1) + 2 * (r - 1) + 4 * (p - 1)];
               else
                  value = ((c + r + p) % 2 == 1) ? VALUE_MAX : VALUE_MIN;
               send_coarse_sample(value, (p == 2 && r == 2 && c == 2) ? 8'hFF : 8'h00);
            end
      drain_results();
   endtask

   task automatic test_undersized_axes();
      write_register(CSR_SPARE_INDEX, 9'h1FF);
      program_grid(9'h100, 9'd3, 9'd3, 9'd1, 9'd1);
      send_grids(1);
      drain_results();
      program_grid(9'd2, 9'd3, 9'd3, 9'd0, 9'd511);
      send_grids(1);
      drain_results();
      program_grid(9'd3, 9'd1, 9'd3, 9'd5, 9'd5);
      send_grids(1);
      drain_results();
      program_grid(9'd3, 9'd3, 9'd2, 9'd5, 9'd5);
      send_grids(1);
      drain_results();
      program_grid(9'd3, 9'd3, 9'd0, 9'd5, 9'd5);
      send_grids(1);
      drain_results();
   endtask

   task automatic test_resize_mid_grid();
      program_grid(9'd5, 9'd5, 9'd3, 9'd9, 9'd9);
      set_idling(1'b0, 1'b0, 1'b0);
      send_grids(1);
      for (int n = 0; n < 38; n++) send_random_sample();
      drain_results();
      // shrink both axes; the column count now sits at the new width
      program_grid(9'd3, 9'd4, 9'd3, 9'd5, 9'd7);
      while (col_pos != 0 || row_pos != 0 || plane_pos != 0) send_random_sample();
      drain_results();
   endtask

   task automatic test_saturated_depth();
      program_grid(9'd3, 9'd3, 9'h0FF, 9'd511, 9'd511);
      set_idling(1'b1, 1'b1, 1'b1);
      // run several planes into a saturated depth
      for (int n = 0; n < 36; n++) send_random_sample();
      drain_results();
      // fold the depth back so the plane count wraps after this plane
      program_grid(9'd3, 9'd3, 9'd3, 9'd511, 9'd511);
      while (col_pos != 0 || row_pos != 0 || plane_pos != 0) send_random_sample();
      drain_results();
   endtask

   task automatic test_random_grids();
      int unsigned cols, rows, planes, grids;
      while (random_items < RANDOM_ITEMS) begin
         cols   = pick_span();
         rows   = pick_span();
         planes = pick_span();
         program_grid(9'(cols), 9'(rows), 9'(planes), pick_fine_size(cols), pick_fine_size(rows));
         set_idling($urandom_range(3) == 0, $urandom_range(3) == 0, 1'b0);
         grids = (cols * rows * planes <= 48 && $urandom_range(9) < 3) ? 2 : 1;
         send_grids(grids);
         random_items += cols * rows * planes * grids;
         drain_results();
      end
   endtask

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.coarse_value = '0;
      req_bus.fine_mask    = '0;
      rsp_bus.ready        = 1'b0;
      csr_write_enable     = 1'b0;
      csr_index            = '0;
      csr_write_data       = '0;
      col_pos         = 0;
      row_pos         = 0;
      plane_pos       = 0;
      coarse_cols     = 8'd64;
      coarse_rows     = 8'd64;
      coarse_planes   = 8'd64;
      fine_row_len    = 9'd127;
      fine_plane_rows = 9'd127;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_extreme_values();
      test_undersized_axes();
      test_resize_mid_grid();
      test_saturated_depth();
      test_random_grids();
      drain_results();

      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
